// ----- src/rtm_pkg.sv -----
package rtm_pkg;

  localparam int LANES    = 4;
  localparam int ElemW    = 16;
  localparam int ProdW    = 2 * ElemW;
  localparam int AccW     = ProdW + 2;
  localparam int FracW    = 8;
  localparam int CfgIdxW  = 8;
  localparam int CoefRowW = LANES * ElemW;

  typedef logic signed [ElemW-1:0] q88_t;
  typedef logic [CoefRowW-1:0]     coef_row_t;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CFG_ROW0 = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW1 = 8'd1;
  localparam logic [CfgIdxW-1:0] CFG_ROW2 = 8'd2;
  localparam logic [CfgIdxW-1:0] CFG_ROW3 = 8'd3;

  localparam coef_row_t COEF_ROW0_RST = 64'h0000_0000_0000_1000;
  localparam coef_row_t COEF_ROW1_RST = 64'h0000_0000_0100_0000;
  localparam coef_row_t COEF_ROW2_RST = 64'h0000_0100_0000_0000;
  localparam coef_row_t COEF_ROW3_RST = 64'h0100_0000_0000_0000;

  // load enables of the two pipeline stages ahead of the output register
  typedef struct packed {
    logic adv1;
    logic adv2;
  } pipe_ctrl_t;

endpackage

// ----- src/rtm_lane.sv -----
module rtm_lane (
  input  logic                clk,
  input  rtm_pkg::pipe_ctrl_t ctrl,
  input  rtm_pkg::q88_t       vec  [rtm_pkg::LANES],
  input  rtm_pkg::q88_t       coef [rtm_pkg::LANES],
  output rtm_pkg::q88_t       res,
  output logic                sat
);
  import rtm_pkg::*;

  localparam logic signed [AccW-1:0] RndHalf = AccW'(1 << (FracW - 1));
  localparam logic signed [AccW-1:0] SatMax  = AccW'(32767);
  localparam logic signed [AccW-1:0] SatMin  = -AccW'(32768);

  logic signed [ProdW-1:0] prod_r [LANES];
  logic signed [AccW-1:0]  sum_r;
  logic signed [AccW-1:0]  sum_nxt;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-1:0]  shifted;

  always_ff @(posedge clk) begin
    if (ctrl.adv1) begin
      for (int i = 0; i < LANES; i++) begin
        prod_r[i] <= ProdW'($signed(vec[i]) * $signed(coef[i]));
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sum_nxt = sum_nxt + AccW'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv2) begin
      sum_r <= sum_nxt;
    end
  end

  // round half up: add half an LSB, then floor shift
  always_comb begin
    rnd     = sum_r + RndHalf;
    shifted = rnd >>> FracW;
    if (shifted > SatMax) begin
      res = q88_t'(SatMax[ElemW-1:0]);
      sat = 1'b1;
    end else if (shifted < SatMin) begin
      res = q88_t'(SatMin[ElemW-1:0]);
      sat = 1'b1;
    end else begin
      res = shifted[ElemW-1:0];
      sat = 1'b0;
    end
  end

endmodule

// ----- src/rtm_merge.sv -----
module rtm_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          lane_valid,
  input  rtm_pkg::q88_t lane_res [rtm_pkg::LANES],
  input  logic          lane_sat [rtm_pkg::LANES],
  input  logic          out_stall,
  output logic          adv,
  output logic          out_valid,
  output rtm_pkg::q88_t out_res [rtm_pkg::LANES],
  output logic          out_saturated
);
  import rtm_pkg::*;

  logic valid_r;
  logic valid_nxt;
  q88_t res_r [LANES];
  logic sat_r;
  logic sat_nxt;

  assign adv       = !valid_r || !out_stall;
  assign valid_nxt = adv ? lane_valid : valid_r;

  always_comb begin
    sat_nxt = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      sat_nxt = sat_nxt | lane_sat[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // hold the word while the receiver stalls
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= lane_res;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid     = valid_r;
  assign out_res       = res_r;
  assign out_saturated = sat_r;

endmodule

// ----- src/row_times_matrix_4x4.sv -----
// Row vector times 4x4 matrix, signed Q8.8.
// Input channel: in_valid / in_stall with the four row elements in_vec_e0..3.
// A word is taken at a clock edge where in_valid is high and in_stall low.
// Result channel: out_valid / out_stall with out_res_e0..3 (the dot products
// with matrix columns 0..3, rounded half up and saturated) and out_saturated.
// Configuration: cfg_valid / cfg_ready, cfg_index selects matrix row 0..3,
// cfg_data carries its four coefficients, column 0 in the low bits. Writes
// to other indexes are dropped. cfg_ready is always high; write only while
// the pipeline is empty.
// Throughput: one word per cycle unless the receiver stalls. Each column has its own lane of four
// multipliers and an adder; the merge stage ORs the lane overflow flags.
// Pipeline: the product register, the sum register and the output register.
// Each stage advances whenever the one after it is empty or moving, so
// bubbles collapse and a word is taken while a result waits.
// A stalled receiver fills the pipeline, then in_stall rises.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
// style default rows.
module row_times_matrix_4x4 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rtm_pkg::q88_t                in_vec_e0,
  input  rtm_pkg::q88_t                in_vec_e1,
  input  rtm_pkg::q88_t                in_vec_e2,
  input  rtm_pkg::q88_t                in_vec_e3,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rtm_pkg::q88_t                out_res_e0,
  output rtm_pkg::q88_t                out_res_e1,
  output rtm_pkg::q88_t                out_res_e2,
  output rtm_pkg::q88_t                out_res_e3,
  output logic                         out_saturated,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rtm_pkg::CfgIdxW-1:0]  cfg_index,
  input  rtm_pkg::coef_row_t           cfg_data
);
  import rtm_pkg::*;

  coef_row_t  coef_r   [LANES];
  coef_row_t  coef_nxt [LANES];
  logic       v1_r, v1_nxt;
  logic       v2_r, v2_nxt;
  logic       adv3;
  pipe_ctrl_t ctrl;
  q88_t       vec      [LANES];
  q88_t       lane_res [LANES];
  logic       lane_sat [LANES];
  q88_t       res      [LANES];

  assign cfg_ready = 1'b1;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW0: coef_nxt[0] = cfg_data;
        CFG_ROW1: coef_nxt[1] = cfg_data;
        CFG_ROW2: coef_nxt[2] = cfg_data;
        CFG_ROW3: coef_nxt[3] = cfg_data;
        default:  coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0] <= COEF_ROW0_RST;
      coef_r[1] <= COEF_ROW1_RST;
      coef_r[2] <= COEF_ROW2_RST;
      coef_r[3] <= COEF_ROW3_RST;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // elastic pipeline: a stage loads when it is empty or its successor loads
  assign ctrl.adv2 = !v2_r || adv3;
  assign ctrl.adv1 = !v1_r || ctrl.adv2;
  assign in_stall  = !ctrl.adv1;
  assign v1_nxt    = ctrl.adv1 ? in_valid : v1_r;
  assign v2_nxt    = ctrl.adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  assign vec[0] = in_vec_e0;
  assign vec[1] = in_vec_e1;
  assign vec[2] = in_vec_e2;
  assign vec[3] = in_vec_e3;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    q88_t col [LANES];
    for (genvar i = 0; i < LANES; i++) begin : g_col
      assign col[i] = coef_r[i][j*ElemW +: ElemW];
    end
    rtm_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .vec  (vec),
      .coef (col),
      .res  (lane_res[j]),
      .sat  (lane_sat[j])
    );
  end

  rtm_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .lane_valid    (v2_r),
    .lane_res      (lane_res),
    .lane_sat      (lane_sat),
    .out_stall     (out_stall),
    .adv           (adv3),
    .out_valid     (out_valid),
    .out_res       (res),
    .out_saturated (out_saturated)
  );

  assign out_res_e0 = res[0];
  assign out_res_e1 = res[1];
  assign out_res_e2 = res[2];
  assign out_res_e3 = res[3];

endmodule

// ----- sim/rtm_product_checker.sv -----
`timescale 1ns / 100ps

module rtm_product_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  rtm_pkg::q88_t                in_vec_e0,
  input  rtm_pkg::q88_t                in_vec_e1,
  input  rtm_pkg::q88_t                in_vec_e2,
  input  rtm_pkg::q88_t                in_vec_e3,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  rtm_pkg::q88_t                out_res_e0,
  input  rtm_pkg::q88_t                out_res_e1,
  input  rtm_pkg::q88_t                out_res_e2,
  input  rtm_pkg::q88_t                out_res_e3,
  input  logic                         out_saturated,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [rtm_pkg::CfgIdxW-1:0]  cfg_index,
  input  rtm_pkg::coef_row_t           cfg_data,
  output int                           error_count,
  output int                           pending_rows
);
  import rtm_pkg::*;

  typedef struct packed {
    logic [LANES-1:0][ElemW-1:0] lane;
    logic                        sat;
  } row_product_t;

  coef_row_t    matrix [LANES];
  row_product_t expected_products [$];

  initial begin
    error_count  = 0;
    pending_rows = 0;
  end

  // v * M per lane: exact Q32.16 sum, round half up, clip to 16 bits
  function automatic row_product_t row_product(input logic [LANES-1:0][ElemW-1:0] vec);
    row_product_t      p;
    logic signed [47:0] acc;
    logic signed [47:0] rnd;
    p.sat = 1'b0;
    for (int j = 0; j < LANES; j++) begin
      acc = '0;
      for (int i = 0; i < LANES; i++) begin
        acc = acc + $signed(vec[i]) * $signed(matrix[i][j*ElemW +: ElemW]);
      end
      rnd = (acc + 48'sd128) >>> FracW;
      if (rnd > 48'sd32767) begin
        p.lane[j] = 16'h7FFF;
        p.sat     = 1'b1;
      end else if (rnd < -48'sd32768) begin
        p.lane[j] = 16'h8000;
        p.sat     = 1'b1;
      end else begin
        p.lane[j] = rnd[ElemW-1:0];
      end
    end
    return p;
  endfunction

  always @(posedge clk) begin : watch
    row_product_t got;
    row_product_t want;
    if (!rst_n) begin
      matrix[0] = COEF_ROW0_RST;
      matrix[1] = COEF_ROW1_RST;
      matrix[2] = COEF_ROW2_RST;
      matrix[3] = COEF_ROW3_RST;
      expected_products.delete();
    end else begin
      // compare before pushing: a word taken now cannot leave in the same cycle
      if (out_valid && !out_stall) begin
        got.lane = {out_res_e3, out_res_e2, out_res_e1, out_res_e0};
        got.sat  = out_saturated;
        if (expected_products.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, got);
          error_count++;
        end else begin
          want = expected_products.pop_front();
          for (int j = 0; j < LANES; j++) begin
            if (got.lane[j] !== want.lane[j]) begin
              $display("%0t: res_e%0d expected %0d got %0d", $time, j,
                       $signed(want.lane[j]), $signed(got.lane[j]));
              error_count++;
            end
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated expected %b got %b", $time, want.sat, got.sat);
            error_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_products.push_back(row_product({in_vec_e3, in_vec_e2, in_vec_e1, in_vec_e0}));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROW0: matrix[0] = cfg_data;
          CFG_ROW1: matrix[1] = cfg_data;
          CFG_ROW2: matrix[2] = cfg_data;
          CFG_ROW3: matrix[3] = cfg_data;
          default: ;  // drop writes to unknown rows
        endcase
      end
    end
    pending_rows = expected_products.size();
  end

endmodule

// ----- sim/tb_row_times_matrix_4x4.sv -----
`timescale 1ns / 100ps

module tb_row_times_matrix_4x4;
  import rtm_pkg::*;

  localparam int ROWS_PER_PHASE = 260;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 10;
  localparam int CYCLE_LIMIT    = 200000;

  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               in_valid      = 1'b0;
  logic               in_stall;
  q88_t               in_vec_e0     = '0;
  q88_t               in_vec_e1     = '0;
  q88_t               in_vec_e2     = '0;
  q88_t               in_vec_e3     = '0;
  logic               out_valid;
  logic               out_stall     = 1'b0;
  q88_t               out_res_e0;
  q88_t               out_res_e1;
  q88_t               out_res_e2;
  q88_t               out_res_e3;
  logic               out_saturated;
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index     = '0;
  coef_row_t          cfg_data      = '0;
  int                 error_count;
  int                 pending_rows;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req_cnt  = 0;
  int hold_taken    = 0;
  int hold_left     = 0;

  always #5 clk = ~clk;

  row_times_matrix_4x4 DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_vec_e0     (in_vec_e0),
    .in_vec_e1     (in_vec_e1),
    .in_vec_e2     (in_vec_e2),
    .in_vec_e3     (in_vec_e3),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res_e0    (out_res_e0),
    .out_res_e1    (out_res_e1),
    .out_res_e2    (out_res_e2),
    .out_res_e3    (out_res_e3),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rtm_product_checker u_checker (.*);

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_taken != hold_req_cnt) begin
      hold_taken <= hold_req_cnt;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL row_times_matrix_4x4");
    $finish;
  end

  function automatic q88_t rand_elem();
    case ($urandom_range(0, 9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2, 3, 4: return q88_t'($urandom);
      default: return q88_t'(int'($urandom_range(0, 2047)) - 1024);
    endcase
  endfunction

  function automatic coef_row_t rand_coef_row();
    coef_row_t r;
    for (int j = 0; j < LANES; j++) r[j*ElemW +: ElemW] = rand_elem();
    return r;
  endfunction

  // hold the word until taken; keep valid high for the next one
  task automatic send_row(input q88_t a, input q88_t b, input q88_t c, input q88_t d);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_vec_e0 <= a;
    in_vec_e1 <= b;
    in_vec_e2 <= c;
    in_vec_e3 <= d;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_rows == 0);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input coef_row_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write all four rows, then one write to an index with no row behind it
  task automatic load_matrix(input coef_row_t r0, input coef_row_t r1,
                             input coef_row_t r2, input coef_row_t r3);
    drain();
    cfg_write(CFG_ROW0, r0);
    cfg_write(CFG_ROW1, r1);
    cfg_write(CFG_ROW2, r2);
    cfg_write(CFG_ROW3, r3);
    cfg_write(CfgIdxW'($urandom_range(LANES, 255)), {$urandom, $urandom});
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int idle, input int stall, input bit hold);
    q88_t e3;
    load_matrix(rand_coef_row(), rand_coef_row(), rand_coef_row(), rand_coef_row());
    send_idle_pct = idle;
    stall_pct     = stall;
    if (hold) hold_req_cnt++;
    repeat (ROWS_PER_PHASE) begin
      e3 = ($urandom_range(0, 7) == 0) ? q88_t'(0) : rand_elem();
      send_row(rand_elem(), rand_elem(), rand_elem(), e3);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default rows: lane 0 scaled by 16, others pass through
    send_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_row(16'sh0100, 16'sh0200, -16'sh0100, 16'sh0080);
    send_row(16'sh07FF, 16'sh0001, -16'sh0001, 16'sh0000);
    send_row(16'sh0800, 16'sh0000, 16'sh0000, 16'sh0000);

    // half coefficients: ties round toward plus infinity
    load_matrix({4{16'h0080}}, {4{16'h0080}}, {4{16'h0080}}, {4{16'h0080}});
    send_row(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    send_row(-16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    send_row(16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000);
    send_row(-16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000);

    load_matrix({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}});
    send_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_row(16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);

    load_matrix({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}});
    send_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_row(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_row(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);

    // first phase streams into a held-off receiver to fill the pipeline
    random_phase(0, 0, 1'b1);
    random_phase(55, 0, 1'b0);
    random_phase(0, 55, 1'b0);
    random_phase(34, 34, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS row_times_matrix_4x4");
    end else begin
      $display("FAIL row_times_matrix_4x4");
    end
    $finish;
  end

endmodule
